@@ design/ble_adv_wake_parser_unit_macros.svh @@
// assertion macros for the advertisement wake parser
`ifndef BLE_ADV_WAKE_PARSER_UNIT_MACROS_SVH
`define BLE_ADV_WAKE_PARSER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define BAWP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("bawp check failed");
// property checked also while reset is high
`define BAWP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bawp reset check failed");
`else
`define BAWP_ASSERT(lbl, prop)
`define BAWP_ASSERT_RST(lbl, prop)
`endif

`endif

@@ design/bawp_pkg.sv @@
// shared types and constants for the advertisement wake parser
package bawp_pkg;

  // manufacturer structure geometry
  localparam int MFG_LEN = 26;
  localparam int MAX_ADV = 31;
  localparam logic [7:0] MFG_STRUCT_LEN = 8'(MFG_LEN + 1);
  localparam logic [7:0] MAX_ADV_LEN = 8'(MAX_ADV);

  // byte values of interest
  localparam logic [7:0] TYPE_MFG   = 8'hff;
  localparam logic [7:0] COMPANY_LO = 8'h53;
  localparam logic [7:0] COMPANY_HI = 8'h05;
  localparam logic [7:0] VENDOR_LO  = 8'h7e;
  localparam logic [7:0] VENDOR_HI  = 8'h05;

  // field positions inside the manufacturer structure
  localparam logic [7:0] FLD_COMPANY_LO = 8'd0;
  localparam logic [7:0] FLD_COMPANY_HI = 8'd1;
  localparam logic [7:0] FLD_VENDOR_LO  = 8'd5;
  localparam logic [7:0] FLD_VENDOR_HI  = 8'd6;
  localparam logic [7:0] FLD_PID_LO     = 8'd7;
  localparam logic [7:0] FLD_PID_HI     = 8'd8;
  localparam logic [7:0] FLD_FLAG       = 8'd11;
  localparam logic [7:0] FLD_MAC0       = 8'd12;
  localparam logic [7:0] MAC_BYTES      = 8'd6;

  // structure offset codes
  localparam logic [7:0] OFS_LENGTH = 8'd0;
  localparam logic [7:0] OFS_TYPE   = 8'd1;

  // queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       is_mfg_type;
    logic       is_mfg_len;
    logic       is_company_lo;
    logic       is_company_hi;
    logic       is_vendor_lo;
    logic       is_vendor_hi;
  } bawp_word_t;

endpackage

@@ design/bawp_front.sv @@
// front end: classifies each incoming byte against the values the walker needs
module bawp_front (
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output bawp_pkg::bawp_word_t word
);
  import bawp_pkg::*;

  // byte compares done ahead of the walker
  always_comb begin
    word.data          = data_byte;
    word.last          = last_byte;
    word.is_zero       = (data_byte == 8'd0);
    word.is_mfg_type   = (data_byte == TYPE_MFG);
    word.is_mfg_len    = (data_byte == MFG_STRUCT_LEN);
    word.is_company_lo = (data_byte == COMPANY_LO);
    word.is_company_hi = (data_byte == COMPANY_HI);
    word.is_vendor_lo  = (data_byte == VENDOR_LO);
    word.is_vendor_hi  = (data_byte == VENDOR_HI);
  end

endmodule

@@ design/bawp_queue.sv @@
// short register queue between the front end and the walker
module bawp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bawp_pkg::bawp_word_t push_word,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output bawp_pkg::bawp_word_t word
);
  import bawp_pkg::*;

  bawp_word_t          entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign valid = (count != '0);
  assign word  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_word;
  end

endmodule

@@ design/bawp_back.sv @@
// back end: walks length-type structures and holds the result word
module bawp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  bawp_pkg::bawp_word_t q_word,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 wake_hit,
  output logic [15:0]          product_id,
  output logic [7:0]           type_flag,
  output logic [47:0]          console_mac,
  output logic [4:0]           adv_length
);
  import bawp_pkg::*;

  // frame state
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  struct_offset, struct_offset_next;
  logic [7:0]  struct_length, struct_length_next;
  logic        struct_len_ok, struct_len_ok_next;
  logic        struct_is_mfg, struct_is_mfg_next;
  logic        walk_stopped, walk_stopped_next;
  logic        frame_failed, frame_failed_next;
  logic        mfg_seen, mfg_seen_next;
  logic [15:0] held_product_id, held_product_id_next;
  logic [7:0]  held_flag, held_flag_next;
  logic [47:0] held_mac, held_mac_next;

  logic [7:0]  field_idx;
  logic [7:0]  mac_ofs;
  logic        mfg_now;
  logic        fail_now;
  logic        hit;
  logic        load_result;

  // take a word unless it would finish a frame onto a blocked result
  assign q_pop       = q_valid && (!q_word.last || !result_valid || !result_stall);
  assign load_result = q_pop && q_word.last;
  assign field_idx   = struct_offset - 8'd2;
  assign mac_ofs     = field_idx - FLD_MAC0;

  // structure walk for one byte
  always_comb begin
    byte_count_next      = (byte_count == 8'hff) ? byte_count : byte_count + 8'd1;
    struct_offset_next   = struct_offset;
    struct_length_next   = struct_length;
    struct_len_ok_next   = struct_len_ok;
    struct_is_mfg_next   = struct_is_mfg;
    walk_stopped_next    = walk_stopped;
    frame_failed_next    = frame_failed;
    mfg_seen_next        = mfg_seen;
    held_product_id_next = held_product_id;
    held_flag_next       = held_flag;
    held_mac_next        = held_mac;
    mfg_now              = struct_is_mfg;
    fail_now             = 1'b0;

    if (!walk_stopped && !frame_failed) begin
      if (struct_offset == OFS_LENGTH) begin
        // length byte; a trailing one is dropped
        if (!q_word.last) begin
          if (q_word.is_zero) begin
            walk_stopped_next = 1'b1;
          end else begin
            struct_length_next = q_word.data;
            struct_len_ok_next = q_word.is_mfg_len;
            struct_offset_next = OFS_TYPE;
            struct_is_mfg_next = 1'b0;
          end
        end
      end else begin
        if (struct_offset == OFS_TYPE) begin
          // type byte
          if (q_word.is_mfg_type) begin
            mfg_now = 1'b1;
            if (!struct_len_ok) fail_now = 1'b1;
          end
        end else if (struct_is_mfg) begin
          // manufacturer field checks and captures
          priority if (field_idx == FLD_COMPANY_LO) begin
            if (!q_word.is_company_lo) fail_now = 1'b1;
          end else if (field_idx == FLD_COMPANY_HI) begin
            if (!q_word.is_company_hi) fail_now = 1'b1;
          end else if (field_idx == FLD_VENDOR_LO) begin
            if (!q_word.is_vendor_lo) fail_now = 1'b1;
          end else if (field_idx == FLD_VENDOR_HI) begin
            if (!q_word.is_vendor_hi) fail_now = 1'b1;
          end else if (field_idx == FLD_PID_LO) begin
            held_product_id_next[7:0] = q_word.data;
          end else if (field_idx == FLD_PID_HI) begin
            held_product_id_next[15:8] = q_word.data;
          end else if (field_idx == FLD_FLAG) begin
            held_flag_next = q_word.data;
          end else if (field_idx >= FLD_MAC0 && mac_ofs < MAC_BYTES) begin
            held_mac_next[{mac_ofs[2:0], 3'b000} +: 8] = q_word.data;
          end else begin
            fail_now = 1'b0;
          end
        end

        // fail the frame, or advance or close the structure
        if (fail_now) begin
          frame_failed_next  = 1'b1;
          struct_is_mfg_next = mfg_now;
        end else if (struct_offset == struct_length) begin
          if (mfg_now) mfg_seen_next = 1'b1;
          struct_offset_next = OFS_LENGTH;
          struct_is_mfg_next = 1'b0;
        end else if (q_word.last) begin
          frame_failed_next = 1'b1;
        end else begin
          struct_offset_next = struct_offset + 8'd1;
          struct_is_mfg_next = mfg_now;
        end
      end
    end

    hit = mfg_seen_next && !frame_failed_next && (byte_count_next <= MAX_ADV_LEN);
  end

  // frame state registers, cleared at the end of every frame
  always_ff @(posedge clk) begin
    if (rst || load_result) begin
      byte_count    <= '0;
      struct_offset <= OFS_LENGTH;
      struct_length <= '0;
      struct_len_ok <= 1'b0;
      struct_is_mfg <= 1'b0;
      walk_stopped  <= 1'b0;
      frame_failed  <= 1'b0;
      mfg_seen      <= 1'b0;
    end else if (q_pop) begin
      byte_count    <= byte_count_next;
      struct_offset <= struct_offset_next;
      struct_length <= struct_length_next;
      struct_len_ok <= struct_len_ok_next;
      struct_is_mfg <= struct_is_mfg_next;
      walk_stopped  <= walk_stopped_next;
      frame_failed  <= frame_failed_next;
      mfg_seen      <= mfg_seen_next;
    end
  end

  // captured manufacturer fields
  always_ff @(posedge clk) begin
    if (q_pop) begin
      held_product_id <= held_product_id_next;
      held_flag       <= held_flag_next;
      held_mac        <= held_mac_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      wake_hit    <= hit;
      product_id  <= hit ? held_product_id_next : 16'd0;
      type_flag   <= hit ? held_flag_next : 8'd0;
      console_mac <= hit ? held_mac_next : 48'd0;
      adv_length  <= hit ? byte_count_next[4:0] : 5'd0;
    end
  end

endmodule

@@ design/ble_adv_wake_parser_unit.sv @@
// Advertisement wake parser top level: classifier, byte queue and structure walker.
// Throughput: one byte per cycle while byte_stall is low.
// The final byte passes the queue, then the walker's result register; words queued ahead delay it.
// A stalled result holds the walker only at the next final byte; the 4-word queue
// absorbs the bytes in between. Reset is synchronous and clears the queue,
// the frame state and the result valid.
module ble_adv_wake_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        wake_hit,
  output logic [15:0] product_id,
  output logic [7:0]  type_flag,
  output logic [47:0] console_mac,
  output logic [4:0]  adv_length
);
  import bawp_pkg::*;

  `include "ble_adv_wake_parser_unit_macros.svh"

  bawp_word_t front_word;
  bawp_word_t q_word;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       q_push;

  assign byte_stall = q_full;
  assign q_push     = byte_valid && !q_full;

  // byte classifier
  bawp_front u_front (
    .data_byte (data_byte),
    .last_byte (last_byte),
    .word      (front_word)
  );

  // decoupling queue
  bawp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .word      (q_word)
  );

  // structure walker and result register
  bawp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .wake_hit     (wake_hit),
    .product_id   (product_id),
    .type_flag    (type_flag),
    .console_mac  (console_mac),
    .adv_length   (adv_length)
  );

  // checks
  `BAWP_ASSERT(a_miss_is_zero, result_valid && !wake_hit |-> product_id == 16'd0 && type_flag == 8'd0 && console_mac == 48'd0 && adv_length == 5'd0)
  `BAWP_ASSERT(a_result_from_last, $rose(result_valid) |-> $past(q_pop && q_word.last))
  `BAWP_ASSERT(a_pop_needs_word, q_pop |-> q_valid)
  `BAWP_ASSERT_RST(a_reset_clears, rst |=> !result_valid && !q_valid)

endmodule

@@ dv/ble_adv_wake_parser_unit_check.sv @@
`timescale 1ns / 100ps
// checker for the advertisement wake parser: predicts each frame's result word and compares
module ble_adv_wake_parser_unit_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        wake_hit,
  input  logic [15:0] product_id,
  input  logic [7:0]  type_flag,
  input  logic [47:0] console_mac,
  input  logic [4:0]  adv_length,
  output int          mismatch_count,
  output int          reports_due
);
  import bawp_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [15:0] pid;
    logic [7:0]  flag;
    logic [47:0] mac;
    logic [4:0]  len;
  } wake_word_t;

  // result words still owed by the block, oldest first
  wake_word_t expected_words[$];

  int mismatches = 0;
  int words_due = 0;

  assign mismatch_count = mismatches;
  assign reports_due = words_due;

  // frame walk state of the prediction
  logic [7:0]  frame_bytes;
  logic [7:0]  walk_pos;
  logic [7:0]  walk_len;
  logic        in_mfg;
  logic        walk_done;
  logic        frame_bad;
  logic        mfg_found;
  logic [15:0] pid_keep;
  logic [7:0]  flag_keep;
  logic [47:0] mac_keep;

  task clear_frame();
    frame_bytes = '0;
    walk_pos = OFS_LENGTH;
    walk_len = '0;
    in_mfg = 1'b0;
    walk_done = 1'b0;
    frame_bad = 1'b0;
    mfg_found = 1'b0;
    pid_keep = '0;
    flag_keep = '0;
    mac_keep = '0;
  endtask

  // id checks and captures inside a manufacturer structure
  task note_mfg_field(input logic [7:0] k, input logic [7:0] b);
    case (k)
      FLD_COMPANY_LO: if (b != COMPANY_LO) frame_bad = 1'b1;
      FLD_COMPANY_HI: if (b != COMPANY_HI) frame_bad = 1'b1;
      FLD_VENDOR_LO:  if (b != VENDOR_LO) frame_bad = 1'b1;
      FLD_VENDOR_HI:  if (b != VENDOR_HI) frame_bad = 1'b1;
      FLD_PID_LO:     pid_keep[7:0] = b;
      FLD_PID_HI:     pid_keep[15:8] = b;
      FLD_FLAG:       flag_keep = b;
      default: begin
        // mac bytes arrive low byte first
        if (k >= FLD_MAC0 && k < FLD_MAC0 + MAC_BYTES) mac_keep[8 * (k - FLD_MAC0) +: 8] = b;
      end
    endcase
  endtask

  // one step of the length-type walk
  task walk_step(input logic [7:0] b, input logic fin);
    if (!walk_done && !frame_bad) begin
      if (walk_pos == OFS_LENGTH) begin
        // a length byte that ends the frame is ignored
        if (!fin) begin
          if (b == 8'h00) begin
            walk_done = 1'b1;
          end else begin
            walk_len = b;
            walk_pos = OFS_TYPE;
            in_mfg = 1'b0;
          end
        end
      end else begin
        if (walk_pos == OFS_TYPE) begin
          if (b == TYPE_MFG) begin
            in_mfg = 1'b1;
            if (walk_len != MFG_STRUCT_LEN) frame_bad = 1'b1;
          end
        end else if (in_mfg) begin
          note_mfg_field(walk_pos - 8'd2, b);
        end
        if (!frame_bad) begin
          if (walk_pos == walk_len) begin
            if (in_mfg) mfg_found = 1'b1;
            walk_pos = OFS_LENGTH;
            in_mfg = 1'b0;
          end else if (fin) begin
            // frame ended inside a structure
            frame_bad = 1'b1;
          end else begin
            walk_pos = walk_pos + 8'd1;
          end
        end
      end
    end
  endtask

  task take_byte(input logic [7:0] b, input logic fin);
    wake_word_t w;
    if (frame_bytes != 8'hff) frame_bytes = frame_bytes + 8'd1;
    walk_step(b, fin);
    if (fin) begin
      w = '0;
      if (mfg_found && !frame_bad && frame_bytes <= MAX_ADV_LEN) begin
        w.hit = 1'b1;
        w.pid = pid_keep;
        w.flag = flag_keep;
        w.mac = mac_keep;
        w.len = frame_bytes[4:0];
      end
      expected_words.push_back(w);
      clear_frame();
    end
  endtask

  task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s is %0h, expected %0h", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // compare one accepted result word with the oldest prediction
  task check_word();
    wake_word_t w;
    if (expected_words.size() == 0) begin
      flag_mismatch("unexpected result word, wake_hit", 64'(wake_hit), 64'd0);
    end else begin
      w = expected_words.pop_front();
      if (wake_hit !== w.hit) flag_mismatch("wake_hit", 64'(wake_hit), 64'(w.hit));
      if (product_id !== w.pid) flag_mismatch("product_id", 64'(product_id), 64'(w.pid));
      if (type_flag !== w.flag) flag_mismatch("type_flag", 64'(type_flag), 64'(w.flag));
      if (console_mac !== w.mac) flag_mismatch("console_mac", 64'(console_mac), 64'(w.mac));
      if (adv_length !== w.len) flag_mismatch("adv_length", 64'(adv_length), 64'(w.len));
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      expected_words.delete();
    end else begin
      if (result_valid && !result_stall) check_word();
      if (byte_valid && !byte_stall) take_byte(data_byte, last_byte);
    end
    words_due <= expected_words.size();
  end

endmodule

@@ dv/ble_adv_wake_parser_unit_test.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the advertisement wake parser
module ble_adv_wake_parser_unit_test;
  import bawp_pkg::*;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_LEN,
    SHAPE_BAD_ID,
    SHAPE_TRUNC,
    SHAPE_TWICE,
    SHAPE_PLAIN,
    SHAPE_NOISE
  } frame_shape_t;

  localparam int NO_SPOIL = -1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        result_stall = 1'b0;
  logic        byte_stall;
  logic        result_valid;
  logic        wake_hit;
  logic [15:0] product_id;
  logic [7:0]  type_flag;
  logic [47:0] console_mac;
  logic [4:0]  adv_length;
  int          mismatch_count;
  int          reports_due;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  logic [7:0] frame_buf[$];

  initial begin
    forever #5 clk = ~clk;
  end

  ble_adv_wake_parser_unit i_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .wake_hit(wake_hit),
    .product_id(product_id),
    .type_flag(type_flag),
    .console_mac(console_mac),
    .adv_length(adv_length)
  );

  ble_adv_wake_parser_unit_check i_check (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .wake_hit(wake_hit),
    .product_id(product_id),
    .type_flag(type_flag),
    .console_mac(console_mac),
    .adv_length(adv_length),
    .mismatch_count(mismatch_count),
    .reports_due(reports_due)
  );

  // random receiver stall
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // hand one byte to the block, with random idle cycles ahead of it
  task push_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task send_frame();
    for (int i = 0; i < frame_buf.size(); i++) push_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
    frames_sent++;
  endtask

  // hold the sender until every result word has come back
  task drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  // manufacturer structure, optionally with one id byte corrupted
  task add_mfg(input logic [7:0] len_byte, input logic [15:0] pid, input logic [7:0] flag,
               input logic [47:0] mac, input int spoil);
    logic [7:0] v;
    frame_buf.push_back(len_byte);
    frame_buf.push_back(TYPE_MFG);
    for (int k = 0; k < MFG_LEN; k++) begin
      v = 8'($urandom_range(255));
      case (k)
        FLD_COMPANY_LO: v = COMPANY_LO;
        FLD_COMPANY_HI: v = COMPANY_HI;
        FLD_VENDOR_LO:  v = VENDOR_LO;
        FLD_VENDOR_HI:  v = VENDOR_HI;
        FLD_PID_LO:     v = pid[7:0];
        FLD_PID_HI:     v = pid[15:8];
        FLD_FLAG:       v = flag;
        default: begin
          if (k >= FLD_MAC0 && k < FLD_MAC0 + MAC_BYTES) v = mac[8 * (k - FLD_MAC0) +: 8];
        end
      endcase
      if (k == spoil) v = v ^ 8'($urandom_range(1, 255));
      frame_buf.push_back(v);
    end
  endtask

  // structure of some other type; len counts the type byte
  task add_plain(input int len);
    frame_buf.push_back(8'(len));
    frame_buf.push_back(8'($urandom_range(0, 254)));
    repeat (len - 1) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  task add_random(input int n);
    repeat (n) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  function int pick_id_field();
    case ($urandom_range(3))
      0: pick_id_field = FLD_COMPANY_LO;
      1: pick_id_field = FLD_COMPANY_HI;
      2: pick_id_field = FLD_VENDOR_LO;
      default: pick_id_field = FLD_VENDOR_HI;
    endcase
  endfunction

  // random frame, mostly well formed with random content
  task build_random_frame();
    frame_shape_t shape;
    int pick;
    logic [15:0] pid;
    logic [7:0] flag;
    logic [47:0] mac;
    pick = $urandom_range(99);
    if (pick < 50) shape = SHAPE_GOOD;
    else if (pick < 58) shape = SHAPE_BAD_LEN;
    else if (pick < 68) shape = SHAPE_BAD_ID;
    else if (pick < 76) shape = SHAPE_TRUNC;
    else if (pick < 82) shape = SHAPE_TWICE;
    else if (pick < 90) shape = SHAPE_PLAIN;
    else shape = SHAPE_NOISE;
    pid = 16'($urandom);
    flag = 8'($urandom);
    mac = {16'($urandom), 32'($urandom)};

    // optional leading structure ahead of the manufacturer one
    if (shape != SHAPE_PLAIN && shape != SHAPE_NOISE) begin
      case ($urandom_range(3))
        0: ;
        1: add_plain(1);
        2: add_plain(2);
        default: add_plain($urandom_range(1, 6));
      endcase
    end

    case (shape)
      SHAPE_GOOD:    add_mfg(MFG_STRUCT_LEN, pid, flag, mac, NO_SPOIL);
      SHAPE_BAD_LEN: add_mfg(MFG_STRUCT_LEN ^ 8'($urandom_range(1, 255)), pid, flag, mac, NO_SPOIL);
      SHAPE_BAD_ID:  add_mfg(MFG_STRUCT_LEN, pid, flag, mac, pick_id_field());
      SHAPE_TRUNC: begin
        add_mfg(MFG_STRUCT_LEN, pid, flag, mac, NO_SPOIL);
        repeat ($urandom_range(1, MFG_LEN)) void'(frame_buf.pop_back());
      end
      SHAPE_TWICE: begin
        add_mfg(MFG_STRUCT_LEN, pid, flag, mac, NO_SPOIL);
        add_mfg(MFG_STRUCT_LEN, ~pid, ~flag, ~mac,
                ($urandom_range(1) == 0) ? NO_SPOIL : pick_id_field());
      end
      SHAPE_PLAIN: repeat ($urandom_range(1, 4)) add_plain($urandom_range(1, 8));
      default:     add_random($urandom_range(1, 40));
    endcase

    // trailing stop byte, padding, lone length byte or short plain structure
    if (shape != SHAPE_TRUNC && shape != SHAPE_NOISE) begin
      case ($urandom_range(4))
        0: ;
        1: frame_buf.push_back(8'h00);
        2: begin
          frame_buf.push_back(8'h00);
          add_random($urandom_range(1, 3));
        end
        3: frame_buf.push_back(8'($urandom_range(255)));
        default: add_plain(1);
      endcase
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("ble_adv_wake_parser_unit_test failed");
    $finish;
  end

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    int phase_bytes;
    int phase_frames;
    idle_plan = '{0, 51, 0, 22};
    stall_plan = '{0, 0, 51, 22};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // lone length byte frames, zero and nonzero
    frame_buf.push_back(8'h00);
    send_frame();
    frame_buf.push_back(8'hff);
    send_frame();

    // held fields at their extremes; second frame is exactly the longest allowed
    add_mfg(MFG_STRUCT_LEN, 16'h0000, 8'h00, 48'h0, NO_SPOIL);
    send_frame();
    add_plain(2);
    add_mfg(MFG_STRUCT_LEN, 16'hffff, 8'hff, 48'hffff_ffff_ffff, NO_SPOIL);
    send_frame();

    // one byte too long
    add_plain(2);
    add_mfg(MFG_STRUCT_LEN, 16'h1234, 8'h5a, 48'h0102_0304_0506, NO_SPOIL);
    frame_buf.push_back(8'h00);
    send_frame();

    // manufacturer type with the wrong length, both sides
    add_mfg(MFG_STRUCT_LEN - 8'd1, 16'h4321, 8'ha5, 48'h0a0b_0c0d_0e0f, NO_SPOIL);
    send_frame();
    add_mfg(MFG_STRUCT_LEN + 8'd1, 16'h4321, 8'ha5, 48'h0a0b_0c0d_0e0f, NO_SPOIL);
    send_frame();

    // each company and vendor byte wrong in turn
    add_mfg(MFG_STRUCT_LEN, 16'h1111, 8'h22, 48'h3333_4444_5555, FLD_COMPANY_LO);
    send_frame();
    add_mfg(MFG_STRUCT_LEN, 16'h1111, 8'h22, 48'h3333_4444_5555, FLD_COMPANY_HI);
    send_frame();
    add_mfg(MFG_STRUCT_LEN, 16'h1111, 8'h22, 48'h3333_4444_5555, FLD_VENDOR_LO);
    send_frame();
    add_mfg(MFG_STRUCT_LEN, 16'h1111, 8'h22, 48'h3333_4444_5555, FLD_VENDOR_HI);
    send_frame();

    // frame ends inside the manufacturer structure
    add_mfg(MFG_STRUCT_LEN, 16'hbeef, 8'h01, 48'hcafe_f00d_1234, NO_SPOIL);
    repeat (5) void'(frame_buf.pop_back());
    send_frame();

    // zero length stops the walk, later bytes only counted
    add_mfg(MFG_STRUCT_LEN, 16'h8001, 8'h80, 48'h8000_0000_0001, NO_SPOIL);
    frame_buf.push_back(8'h00);
    add_random(2);
    send_frame();

    // lone trailing nonzero length byte after a hit
    add_mfg(MFG_STRUCT_LEN, 16'h7ffe, 8'h7f, 48'h7fff_ffff_fffe, NO_SPOIL);
    frame_buf.push_back(8'h1b);
    send_frame();

    // repeated manufacturer structure
    add_mfg(MFG_STRUCT_LEN, 16'haaaa, 8'h55, 48'haaaa_aaaa_aaaa, NO_SPOIL);
    add_mfg(MFG_STRUCT_LEN, 16'h5555, 8'haa, 48'h5555_5555_5555, NO_SPOIL);
    send_frame();

    // byte count saturates past 255
    add_mfg(MFG_STRUCT_LEN, 16'h0f0f, 8'hf0, 48'h0f0f_0f0f_0f0f, NO_SPOIL);
    frame_buf.push_back(8'h00);
    add_random(272);
    send_frame();

    // plain structures only
    add_plain(3);
    add_plain(1);
    send_frame();
    drain();

    // random frames under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      phase_bytes = bytes_sent;
      phase_frames = frames_sent;
      while (bytes_sent - phase_bytes < 75 || frames_sent - phase_frames < 3) begin
        build_random_frame();
        send_frame();
        if ($urandom_range(15) == 0) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ble_adv_wake_parser_unit_test passed");
    end else begin
      $display("ble_adv_wake_parser_unit_test failed");
    end
    $finish;
  end

endmodule
